/* sv/fssl_pkg.sv */
package fssl_pkg;

  // Wait counter width and saturation value
  localparam int unsigned CntW   = 20;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Configuration register widths
  localparam int unsigned InitW  = 16;
  localparam int unsigned DoneW  = 20;
  localparam int unsigned PulseW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // Configuration reset values
  localparam logic [InitW-1:0]  InitWaitRst   = 16'd500;
  localparam logic [DoneW-1:0]  DoneWaitRst   = 20'd50000;
  localparam logic [PulseW-1:0] ResetPulseRst = 16'd10;

  typedef struct packed {
    logic       start_req;
    logic       init_b_pin;
    logic       done_pin;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_last;
  } in_item_t;

  typedef struct packed {
    logic       prog_n;
    logic       cclk;
    logic       din;
    logic       tgt_rst_n;
    logic       byte_taken;
    logic [1:0] status;
    logic [2:0] warnings;
  } out_item_t;

  typedef struct packed {
    logic [InitW-1:0]  init_wait_ticks;
    logic [DoneW-1:0]  done_wait_ticks;
    logic [PulseW-1:0] reset_pulse_ticks;
  } cfg_t;

endpackage

/* sv/fssl_front.sv */
module fssl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fssl_pkg::in_item_t in_item_i,
  output logic              head_valid_o,
  output fssl_pkg::in_item_t head_item_o,
  input  logic              pop_i
);
  import fssl_pkg::*;

  // Two-entry queue between the input port and the sequencer
  in_item_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign pop          = pop_i && head_valid_o;
  assign head_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 && !pop |=> count_q == 2'd2)
    else $error("queue lost or gained an entry while full");
`endif

endmodule

/* sv/fssl_core.sv */
module fssl_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fssl_pkg::cfg_t     cfg_i,
  input  logic               head_valid_i,
  input  fssl_pkg::in_item_t head_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fssl_pkg::out_item_t out_item_o
);
  import fssl_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_PROG_LOW  = 3'd1;
  localparam logic [2:0] PH_PROG_HIGH = 3'd2;
  localparam logic [2:0] PH_LOAD      = 3'd3;
  localparam logic [2:0] PH_SHIFT     = 3'd4;
  localparam logic [2:0] PH_WAIT_DONE = 3'd5;
  localparam logic [2:0] PH_RESET     = 3'd6;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_OK      = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  logic [2:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      shift_q, shift_d;
  logic [2:0]      bit_idx_q, bit_idx_d;
  logic            clk_ph_q, clk_ph_d;
  logic            final_q, final_d;
  logic [2:0]      warn_q, warn_d;
  logic [1:0]      status_q, status_d;
  logic            taken;
  logic            out_valid_q;
  out_item_t       out_q, out_d;
  logic [CntW-1:0] cnt_inc;
  logic            tmo_init, tmo_done, tmo_pulse;

  function automatic logic timed_out(input logic [CntW-1:0] cnt,
                                     input logic [CntW-1:0] limit);
    return (cnt >= limit) || (cnt == CntMax);
  endfunction

  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign cnt_inc   = (cnt_q == CntMax) ? cnt_q : cnt_q + CntW'(1);
  assign tmo_init  = timed_out(cnt_q, CntW'(cfg_i.init_wait_ticks));
  assign tmo_done  = timed_out(cnt_q, CntW'(cfg_i.done_wait_ticks));
  assign tmo_pulse = timed_out(cnt_q, CntW'(cfg_i.reset_pulse_ticks));

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    bit_idx_d = bit_idx_q;
    clk_ph_d  = clk_ph_q;
    final_d   = final_q;
    warn_d    = warn_q;
    status_d  = status_q;
    taken     = 1'b0;
    case (phase_q)
      PH_PROG_LOW: begin
        if (!head_item_i.init_b_pin || tmo_init) begin
          if (head_item_i.init_b_pin) warn_d[0] = 1'b1;
          if (!head_item_i.done_pin)  warn_d[1] = 1'b1;
          phase_d = PH_PROG_HIGH;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_PROG_HIGH: begin
        if (head_item_i.init_b_pin || tmo_init) begin
          if (!head_item_i.init_b_pin) warn_d[2] = 1'b1;
          phase_d = PH_LOAD;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_LOAD: begin
        if (head_item_i.byte_valid) begin
          taken     = 1'b1;
          shift_d   = head_item_i.byte_data;
          final_d   = head_item_i.byte_last;
          bit_idx_d = 3'd0;
          clk_ph_d  = 1'b0;
          phase_d   = PH_SHIFT;
        end
      end
      PH_SHIFT: begin
        if (!clk_ph_q) begin
          clk_ph_d = 1'b1;
        end else if (bit_idx_q == 3'd7) begin
          clk_ph_d  = 1'b0;
          bit_idx_d = 3'd0;
          cnt_d     = '0;
          phase_d   = final_q ? PH_WAIT_DONE : PH_LOAD;
        end else begin
          clk_ph_d  = 1'b0;
          bit_idx_d = bit_idx_q + 3'd1;
        end
      end
      PH_WAIT_DONE: begin
        if (!head_item_i.done_pin) begin
          phase_d = PH_RESET;
          cnt_d   = CntW'(1);
        end else if (tmo_done) begin
          status_d = ST_TIMEOUT;
          phase_d  = PH_IDLE;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_RESET: begin
        if (tmo_pulse) begin
          status_d = ST_OK;
          phase_d  = PH_IDLE;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (head_item_i.start_req) begin
          warn_d   = '0;
          status_d = ST_BUSY;
          cnt_d    = '0;
          final_d  = 1'b0;
          phase_d  = PH_PROG_LOW;
        end
      end
    endcase

    out_d.prog_n     = (phase_d != PH_PROG_LOW);
    out_d.cclk       = (phase_d == PH_SHIFT) && clk_ph_d;
    out_d.din        = (phase_d == PH_SHIFT) && shift_d[3'd7 - bit_idx_d];
    out_d.tgt_rst_n  = (phase_d != PH_RESET);
    out_d.byte_taken = taken;
    out_d.status     = status_d;
    out_d.warnings   = warn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      shift_q     <= '0;
      bit_idx_q   <= '0;
      clk_ph_q    <= 1'b0;
      final_q     <= 1'b0;
      warn_q      <= '0;
      status_q    <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        shift_q   <= shift_d;
        bit_idx_q <= bit_idx_d;
        clk_ph_q  <= clk_ph_d;
        final_q   <= final_d;
        warn_q    <= warn_d;
        status_q  <= status_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_busy_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> status_q == ST_BUSY)
    else $error("status not busy during a sequence");
  a_bit_idx_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q != 3'd0 |-> phase_q == PH_SHIFT)
    else $error("bit index left nonzero outside shifting");
  a_clk_ph_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clk_ph_q |-> phase_q == PH_SHIFT)
    else $error("CCLK phase high outside shifting");
  a_take_starts_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && taken |=> phase_q == PH_SHIFT && !clk_ph_q && out_valid_q)
    else $error("taken byte did not start with CCLK low");
`endif

endmodule

/* sv/fpga_slave_serial_loader.sv */
// Slave-serial configuration sequencer, one input transfer per timing tick.
// Result path: an item passes through its queue entry, then the registered
// result, before the result transfer for it is offered.
// Throughput: one item per cycle while out_stall_i is low; one sequencer step per item.
// Reset: asynchronous active low; sequencer idle, queue empty, registers at
// their defaults (500, 50000, 10). No clearing pass.
module fpga_slave_serial_loader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_req_i,
  input  logic                          init_b_pin_i,
  input  logic                          done_pin_i,
  input  logic                          byte_valid_i,
  input  logic [7:0]                    byte_data_i,
  input  logic                          byte_last_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          prog_n_o,
  output logic                          cclk_o,
  output logic                          din_o,
  output logic                          tgt_rst_n_o,
  output logic                          byte_taken_o,
  output logic [1:0]                    status_o,
  output logic [2:0]                    warnings_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fssl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fssl_pkg::CfgDataW-1:0] cfg_data_i
);
  import fssl_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_INIT_WAIT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DONE_WAIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_PULSE = 2'd2;

  cfg_t      cfg_q, cfg_d;
  in_item_t  in_item;
  in_item_t  head_item;
  logic      head_valid;
  logic      pop;
  out_item_t out_item;
  logic      cfg_we;

  // Accept a register write every cycle; writes to an unused index drop.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_INIT_WAIT:   cfg_d.init_wait_ticks   = cfg_data_i[InitW-1:0];
        CFG_DONE_WAIT:   cfg_d.done_wait_ticks   = cfg_data_i[DoneW-1:0];
        CFG_RESET_PULSE: cfg_d.reset_pulse_ticks = cfg_data_i[PulseW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_wait_ticks   <= InitWaitRst;
      cfg_q.done_wait_ticks   <= DoneWaitRst;
      cfg_q.reset_pulse_ticks <= ResetPulseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pack the pin samples and byte offer into one queued transfer.
  assign in_item.start_req  = start_req_i;
  assign in_item.init_b_pin = init_b_pin_i;
  assign in_item.done_pin   = done_pin_i;
  assign in_item.byte_valid = byte_valid_i;
  assign in_item.byte_data  = byte_data_i;
  assign in_item.byte_last  = byte_last_i;

  // Front: hold incoming ticks; the input side waits on the result side only once the queue is full.
  fssl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .pop_i        (pop)
  );

  // Back: advance the sequencer one tick per popped item, register its result.
  fssl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item)
  );

  assign prog_n_o     = out_item.prog_n;
  assign cclk_o       = out_item.cclk;
  assign din_o        = out_item.din;
  assign tgt_rst_n_o  = out_item.tgt_rst_n;
  assign byte_taken_o = out_item.byte_taken;
  assign status_o     = out_item.status;
  assign warnings_o   = out_item.warnings;

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fssl_pkg::*;

  // Receiver hold-off used to back the block up into its input channel
  localparam int HoldOffCycles = 300;
  // Cycles allowed for the result queue to empty at a phase boundary
  localparam int DrainLimit    = 5000;
  // Cycles to let pass once nothing is pending
  localparam int SettleCycles  = 4;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PROG_LOW,
    SEQ_INIT_HIGH,
    SEQ_LOAD,
    SEQ_SHIFT,
    SEQ_DONE_WAIT,
    SEQ_PULSE
  } seq_phase_t;

  typedef enum logic [1:0] {
    STAT_IDLE,
    STAT_BUSY,
    STAT_OK,
    STAT_TIMEOUT
  } load_status_t;

  typedef enum logic [1:0] {
    REG_INIT_WAIT,
    REG_DONE_WAIT,
    REG_PULSE_LEN,
    REG_SPARE
  } reg_index_t;

  // Warning flag bit positions
  localparam int WarnInitNotLow  = 0;
  localparam int WarnDoneEarly   = 1;
  localparam int WarnInitNotHigh = 2;

  // One directed tick: repeat count, pins offered, and a hand-written
  // expectation where one is given
  typedef struct {
    int        reps;
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } vec_row_t;

  // One stretch of the run under one register setting
  typedef struct {
    logic [CfgDataW-1:0] r_init;
    logic [CfgDataW-1:0] r_done;
    logic [CfgDataW-1:0] r_pulse;
    int                  budget;
    int                  done_pct;
    bit                  calm;
    bit                  squeeze;
    bit                  keep_regs;
  } phase_plan_t;

  // ---------------------------------------------------------------------------
  // Block ports
  // ---------------------------------------------------------------------------
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                start_req_i  = 1'b0;
  logic                init_b_pin_i = 1'b0;
  logic                done_pin_i   = 1'b0;
  logic                byte_valid_i = 1'b0;
  logic [7:0]          byte_data_i  = '0;
  logic                byte_last_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                prog_n_o;
  logic                cclk_o;
  logic                din_o;
  logic                tgt_rst_n_o;
  logic                byte_taken_o;
  logic [1:0]          status_o;
  logic [2:0]          warnings_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;

  fpga_slave_serial_loader dut (.*);

  // Free-running clock, 2 ns period
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sequencer mirror: own copy of the state and the registers, reset values
  // match the block's reset
  // ---------------------------------------------------------------------------
  seq_phase_t        seq_ph    = SEQ_IDLE;
  logic [CntW-1:0]   wait_cnt  = '0;
  logic [7:0]        shift_reg = '0;
  logic [2:0]        bit_idx   = '0;
  logic              clk_ph    = 1'b0;
  logic              last_byte = 1'b0;
  logic [2:0]        warn_bits = '0;
  load_status_t      load_stat = STAT_IDLE;

  logic [InitW-1:0]  cfg_init  = InitWaitRst;
  logic [DoneW-1:0]  cfg_done  = DoneWaitRst;
  logic [PulseW-1:0] cfg_pulse = ResetPulseRst;

  // Pin levels expected for every accepted tick, oldest first
  out_item_t pin_results_q[$];
  out_item_t want_pins;

  // Stimulus knobs used by the sender and the receiver
  bit calm      = 1'b0;
  int done_pct  = 15;
  int hold_req  = 0;
  int hold_left = 0;
  int bytes_left = 0;
  int errors    = 0;

  vec_row_t    dir_rows [13];
  phase_plan_t plans [10];

  // A wait ends once the counter reaches its limit or saturates
  function automatic bit expired(input logic [CntW-1:0] lim);
    return (wait_cnt >= lim) || (wait_cnt == CntMax);
  endfunction

  function automatic void bump();
    if (wait_cnt != CntMax) begin
      wait_cnt++;
    end
  endfunction

  // Advance the mirror by one tick and return the pin levels after it
  function automatic out_item_t sequencer_tick(input in_item_t it);
    out_item_t o;
    logic      took;
    took = 1'b0;
    case (seq_ph)
      SEQ_PROG_LOW: begin
        if (!it.init_b_pin || expired(CntW'(cfg_init))) begin
          if (it.init_b_pin) warn_bits[WarnInitNotLow] = 1'b1;
          if (!it.done_pin) warn_bits[WarnDoneEarly] = 1'b1;
          seq_ph   = SEQ_INIT_HIGH;
          wait_cnt = '0;
        end else begin
          bump();
        end
      end
      SEQ_INIT_HIGH: begin
        if (it.init_b_pin || expired(CntW'(cfg_init))) begin
          if (!it.init_b_pin) warn_bits[WarnInitNotHigh] = 1'b1;
          seq_ph   = SEQ_LOAD;
          wait_cnt = '0;
        end else begin
          bump();
        end
      end
      SEQ_LOAD: begin
        if (it.byte_valid) begin
          took      = 1'b1;
          shift_reg = it.byte_data;
          last_byte = it.byte_last;
          bit_idx   = '0;
          clk_ph    = 1'b0;
          seq_ph    = SEQ_SHIFT;
        end
      end
      SEQ_SHIFT: begin
        if (!clk_ph) begin
          clk_ph = 1'b1;
        end else if (bit_idx == 3'd7) begin
          clk_ph   = 1'b0;
          bit_idx  = '0;
          wait_cnt = '0;
          seq_ph   = last_byte ? SEQ_DONE_WAIT : SEQ_LOAD;
        end else begin
          clk_ph = 1'b0;
          bit_idx++;
        end
      end
      SEQ_DONE_WAIT: begin
        if (!it.done_pin) begin
          seq_ph   = SEQ_PULSE;
          wait_cnt = CntW'(1);
        end else if (expired(cfg_done)) begin
          load_stat = STAT_TIMEOUT;
          seq_ph    = SEQ_IDLE;
        end else begin
          bump();
        end
      end
      SEQ_PULSE: begin
        if (expired(CntW'(cfg_pulse))) begin
          load_stat = STAT_OK;
          seq_ph    = SEQ_IDLE;
        end else begin
          bump();
        end
      end
      default: begin
        seq_ph = SEQ_IDLE;
        if (it.start_req) begin
          warn_bits = '0;
          load_stat = STAT_BUSY;
          wait_cnt  = '0;
          last_byte = 1'b0;
          seq_ph    = SEQ_PROG_LOW;
        end
      end
    endcase

    o.prog_n     = (seq_ph != SEQ_PROG_LOW);
    o.cclk       = (seq_ph == SEQ_SHIFT) ? clk_ph : 1'b0;
    o.din        = (seq_ph == SEQ_SHIFT) ? shift_reg[3'd7 - bit_idx] : 1'b0;
    o.tgt_rst_n  = (seq_ph != SEQ_PULSE);
    o.byte_taken = took;
    o.status     = load_stat;
    o.warnings   = warn_bits;
    return o;
  endfunction

  function automatic in_item_t tick_in(input bit st, input bit ib, input bit dn,
                                       input bit bv, input logic [7:0] bd, input bit bl);
    in_item_t it;
    it.start_req  = st;
    it.init_b_pin = ib;
    it.done_pin   = dn;
    it.byte_valid = bv;
    it.byte_data  = bd;
    it.byte_last  = bl;
    return it;
  endfunction

  function automatic out_item_t pins_out(input bit prog, input bit cc, input bit dbit,
                                         input bit frst, input bit tk,
                                         input load_status_t st, input logic [2:0] w);
    out_item_t o;
    o.prog_n     = prog;
    o.cclk       = cc;
    o.din        = dbit;
    o.tgt_rst_n  = frst;
    o.byte_taken = tk;
    o.status     = st;
    o.warnings   = w;
    return o;
  endfunction

  // Pick the next tick from where the sequencer stands: mostly a plausible
  // FPGA answer, sometimes pure noise
  function automatic in_item_t shape_tick();
    in_item_t    it;
    logic [31:0] r;
    r  = $urandom;
    it = r[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 99) < 10) begin
      return it;
    end
    it.start_req = ($urandom_range(0, 99) < 20);
    case (seq_ph)
      SEQ_IDLE: begin
        it.start_req = ($urandom_range(0, 99) < 30);
      end
      SEQ_PROG_LOW: begin
        it.init_b_pin = !($urandom_range(0, 99) < 25);
        it.done_pin   = !($urandom_range(0, 99) < 10);
      end
      SEQ_INIT_HIGH: begin
        it.init_b_pin = ($urandom_range(0, 99) < 30);
      end
      SEQ_LOAD: begin
        it.byte_valid = ($urandom_range(0, 99) < 70);
        it.byte_last  = (bytes_left <= 1) ^ ($urandom_range(0, 19) == 0);
      end
      SEQ_DONE_WAIT: begin
        it.done_pin = !($urandom_range(0, 99) < done_pct);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Offer one tick, hold it until the transfer, then predict its result
  task automatic send_tick(input in_item_t it, output out_item_t predicted);
    seq_phase_t was;
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_req_i  <= it.start_req;
    init_b_pin_i <= it.init_b_pin;
    done_pin_i   <= it.done_pin;
    byte_valid_i <= it.byte_valid;
    byte_data_i  <= it.byte_data;
    byte_last_i  <= it.byte_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    was       = seq_ph;
    predicted = sequencer_tick(it);
    // Plan the bitstream length of a freshly started sequence
    if (was == SEQ_IDLE && seq_ph == SEQ_PROG_LOW) begin
      bytes_left = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 10)
                                                : $urandom_range(1, 3);
    end
    if (predicted.byte_taken && bytes_left > 0) begin
      bytes_left--;
    end
  endtask

  // Write every register index in turn, the spare one with junk
  task automatic load_regs(input logic [CfgDataW-1:0] v_init,
                           input logic [CfgDataW-1:0] v_done,
                           input logic [CfgDataW-1:0] v_pulse);
    logic [CfgDataW-1:0] vals [4];
    reg_index_t          idx;
    vals[0] = v_init;
    vals[1] = v_done;
    vals[2] = v_pulse;
    vals[3] = CfgDataW'($urandom);
    for (int i = 0; i < 4; i++) begin
      idx = reg_index_t'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx)
        REG_INIT_WAIT: cfg_init  = vals[i][InitW-1:0];
        REG_DONE_WAIT: cfg_done  = vals[i][DoneW-1:0];
        REG_PULSE_LEN: cfg_pulse = vals[i][PulseW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering and let every pending result come out
  task automatic drain_results();
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    while (pin_results_q.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic flag_field(input string fname, input logic [7:0] want,
                            input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each transfer against the oldest prediction, then
  // drive stall for the next cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pin_results_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing pending", $time);
      end else begin
        want_pins = pin_results_q.pop_front();
        flag_field("prog_n", 8'(want_pins.prog_n), 8'(prog_n_o));
        flag_field("cclk", 8'(want_pins.cclk), 8'(cclk_o));
        flag_field("din", 8'(want_pins.din), 8'(din_o));
        flag_field("tgt_rst_n", 8'(want_pins.tgt_rst_n), 8'(tgt_rst_n_o));
        flag_field("byte_taken", 8'(want_pins.byte_taken), 8'(byte_taken_o));
        flag_field("status", 8'(want_pins.status), 8'(status_o));
        flag_field("warnings", 8'(want_pins.warnings), 8'(warnings_o));
      end
    end
    // Hold off for a counted stretch when asked, else stall at random
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    out_item_t predicted;
    int        n;

    // Directed ticks under the reset register values (500, 50000, 10):
    // idle, ignored byte offer, start, start while busy, early DONE,
    // a full 0x80 byte with ignored offers during the shift, the reset
    // pulse, success, and a restart that clears the warnings
    dir_rows = '{
      '{1,  tick_in(0, 0, 0, 0, 8'h00, 0), 1'b1,
            pins_out(1, 0, 0, 1, 0, STAT_IDLE, 3'b000)},
      '{1,  tick_in(0, 1, 1, 1, 8'hFF, 1), 1'b1,
            pins_out(1, 0, 0, 1, 0, STAT_IDLE, 3'b000)},
      '{1,  tick_in(1, 1, 1, 0, 8'h00, 0), 1'b1,
            pins_out(0, 0, 0, 1, 0, STAT_BUSY, 3'b000)},
      '{1,  tick_in(1, 1, 1, 1, 8'hFF, 1), 1'b0, '0},
      '{1,  tick_in(0, 0, 0, 0, 8'h00, 0), 1'b1,
            pins_out(1, 0, 0, 1, 0, STAT_BUSY, 3'b010)},
      '{1,  tick_in(0, 0, 1, 0, 8'h00, 0), 1'b0, '0},
      '{1,  tick_in(0, 1, 1, 0, 8'h00, 0), 1'b0, '0},
      '{1,  tick_in(0, 1, 1, 1, 8'h80, 1), 1'b1,
            pins_out(1, 0, 1, 1, 1, STAT_BUSY, 3'b010)},
      '{16, tick_in(0, 1, 1, 1, 8'h00, 0), 1'b0, '0},
      '{1,  tick_in(0, 1, 0, 0, 8'h00, 0), 1'b1,
            pins_out(1, 0, 0, 0, 0, STAT_BUSY, 3'b010)},
      '{9,  tick_in(1, 0, 0, 1, 8'h55, 0), 1'b0, '0},
      '{1,  tick_in(0, 1, 1, 0, 8'h00, 0), 1'b1,
            pins_out(1, 0, 0, 1, 0, STAT_OK, 3'b010)},
      '{1,  tick_in(1, 0, 0, 0, 8'h00, 0), 1'b1,
            pins_out(0, 0, 0, 1, 0, STAT_BUSY, 3'b000)}
    };

    // Register settings: keep the reset values first, then zero waits,
    // short waits, maximum waits with no idling, values wider than their
    // registers, a long reset pulse, the reset values under a long
    // receiver hold-off, and a few random short settings
    plans[0] = '{20'd0, 20'd0, 20'd0, 150, 15, 1'b0, 1'b0, 1'b1};
    plans[1] = '{20'd0, 20'd0, 20'd0, 120, 20, 1'b0, 1'b0, 1'b0};
    plans[2] = '{20'd3, 20'd5, 20'd1, 200, 20, 1'b0, 1'b0, 1'b0};
    plans[3] = '{20'd65535, 20'hFFFFF, 20'd2, 180, 15, 1'b1, 1'b0, 1'b0};
    plans[4] = '{20'hF0004, 20'h00020, 20'hF0003, 200, 10, 1'b0, 1'b0, 1'b0};
    plans[5] = '{20'd20, 20'd40, 20'd120, 40, 100, 1'b0, 1'b0, 1'b0};
    plans[6] = '{20'd500, 20'd50000, 20'd10, 250, 15, 1'b0, 1'b1, 1'b0};
    for (int k = 7; k < 10; k++) begin
      plans[k] = '{CfgDataW'($urandom_range(0, 12)), CfgDataW'($urandom_range(0, 30)),
                   CfgDataW'($urandom_range(0, 20)), 70, 20, 1'b0, 1'b0, 1'b0};
    end

    // Hold reset at the start, then release it once
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        send_tick(dir_rows[r].stim, predicted);
        pin_results_q.push_back(dir_rows[r].typed ? dir_rows[r].want : predicted);
      end
    end

    // Each phase runs its budget, then on to the end of the sequence in
    // flight, so that registers only change with the sequencer idle
    foreach (plans[p]) begin
      if (!plans[p].keep_regs) begin
        load_regs(plans[p].r_init, plans[p].r_done, plans[p].r_pulse);
      end
      calm     = plans[p].calm;
      done_pct = plans[p].done_pct;
      if (plans[p].squeeze) begin
        hold_req = HoldOffCycles;
      end
      n = 0;
      while (n < plans[p].budget || seq_ph != SEQ_IDLE) begin
        send_tick(shape_tick(), predicted);
        pin_results_q.push_back(predicted);
        n++;
      end
      drain_results();
    end

    if (pin_results_q.size() != 0) begin
      errors += pin_results_q.size();
      $display("%0t: %0d results never arrived", $time, pin_results_q.size());
    end
    if (errors == 0) begin
      $display("** fpga_slave_serial_loader: PASSED **");
    end else begin
      $display("** fpga_slave_serial_loader: FAILED **");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run
  initial begin
    #10ms;
    $display("** fpga_slave_serial_loader: FAILED **");
    $finish;
  end

endmodule

/* fpga_slave_serial_loader.f */
sv/fssl_pkg.sv
sv/fssl_front.sv
sv/fssl_core.sv
sv/fpga_slave_serial_loader.sv
test/tb_top.sv
